/* design/acu_pkg.sv */
package acu_pkg;

   // table geometry
   localparam int TABLE_INDEX_BITS = 8;
   localparam int TABLE_SIZE       = 1 << TABLE_INDEX_BITS;
   localparam int TABLE_LAST       = TABLE_SIZE - 1;

   // field widths
   localparam int MODE_W   = 3;
   localparam int SAMPLE_W = 16;
   localparam int ENTRY_W  = 8;
   localparam int WORD_W   = 12;
   localparam int SLOPE_W  = 12;
   localparam int SCALE_W  = 24;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int PROD_W   = DIFF_W + SCALE_W;
   localparam int POS_FRAC = 16;
   localparam int IND_W    = PROD_W - POS_FRAC;
   localparam int FRAC_W   = 11;
   localparam int MAG_W    = PROD_W - FRAC_W;

   // fixed-point constants
   localparam int Q_ONE        = 2048;
   localparam int LEAK_MAG_MAX = 32768;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   // cycles from an accepted item to its result strobe edge
   localparam int PIPE_LAT = 6;

   // activation modes; codes above MODE_PASS act as pass-through
   localparam logic [MODE_W-1:0] MODE_RELU    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LEAKY   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SIGMOID = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TANH    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PASS    = 3'd4;

   // register map (word index)
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] CSR_MODE        = 3'd0;
   localparam logic [2:0] CSR_LEAK_SLOPE  = 3'd1;
   localparam logic [2:0] CSR_RANGE_LOW   = 3'd2;
   localparam logic [2:0] CSR_RANGE_HIGH  = 3'd3;
   localparam logic [2:0] CSR_INDEX_SCALE = 3'd4;

   localparam logic [SLOPE_W-1:0]         LEAK_SLOPE_RST  = 12'd205;
   localparam logic signed [SAMPLE_W-1:0] RANGE_LOW_RST   = -16'sd16384;
   localparam logic signed [SAMPLE_W-1:0] RANGE_HIGH_RST  = 16'sd16384;
   localparam logic [SCALE_W-1:0]         INDEX_SCALE_RST = 24'd510;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [SLOPE_W-1:0]         leak_slope;
      logic signed [SAMPLE_W-1:0] range_low;
      logic signed [SAMPLE_W-1:0] range_high;
      logic [SCALE_W-1:0]         index_scale;
   } cfg_type;

   // per-item control that travels down the pipeline
   typedef struct packed {
      logic                       eval;
      logic [MODE_W-1:0]          mode;
      logic                       eob;
      logic signed [SAMPLE_W-1:0] x;
      logic                       below;
      logic                       above;
   } item_ctl_type;

   typedef struct packed {
      logic                        en;
      logic [TABLE_INDEX_BITS-1:0] addr;
      logic [WORD_W-1:0]           word;
   } tbl_wr_type;

endpackage

/* design/acu_ram.sv */
module acu_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // write one word, read two with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* design/acu_index.sv */
module acu_index import acu_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       req_opcode,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [ENTRY_W-1:0]         req_entry_index,
   input  logic [WORD_W-1:0]          req_entry_word,
   input  logic                       req_end_of_block,
   input  cfg_type                    cfg,
   output item_ctl_type               ctl,
   output logic [PROD_W-1:0]          prod,
   output tbl_wr_type                 tbl_wr
);

   // capture stage
   logic                       a_eval_ff;
   logic                       a_write_ff;
   logic [MODE_W-1:0]          a_mode_ff;
   logic signed [SAMPLE_W-1:0] a_x_ff;
   logic signed [SAMPLE_W-1:0] a_xe_ff;
   logic                       a_eob_ff;
   logic [TABLE_INDEX_BITS-1:0] a_addr_ff;
   logic [WORD_W-1:0]          a_word_ff;

   logic signed [SAMPLE_W-1:0] dbl;
   logic signed [SAMPLE_W-1:0] a_xe_in;
   logic [ENTRY_W+TABLE_INDEX_BITS-1:0] addr_ext;

   // compare stage
   item_ctl_type      b_ctl_ff;
   item_ctl_type      b_ctl_in;
   tbl_wr_type        b_wr_ff;
   logic [DIFF_W-1:0] b_opa_ff;
   logic [SCALE_W-1:0] b_opb_ff;
   logic [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0] negx;
   logic              use_leak;

   // multiply stage
   item_ctl_type      c_ctl_ff;
   tbl_wr_type        c_wr_ff;
   logic [PROD_W-1:0] c_prod_ff;

   // double the sample with saturation for tanh
   always_comb begin
      if (req_sample[SAMPLE_W-1] != req_sample[SAMPLE_W-2]) begin
         dbl = req_sample[SAMPLE_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         dbl = {req_sample[SAMPLE_W-2:0], 1'b0};
      end
      a_xe_in  = (cfg.mode == MODE_TANH) ? dbl : req_sample;
      addr_ext = {{TABLE_INDEX_BITS{1'b0}}, req_entry_index};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_eval_ff  <= 1'b0;
         a_write_ff <= 1'b0;
      end else begin
         a_eval_ff  <= accept && !req_opcode;
         a_write_ff <= accept && req_opcode;
      end
      a_mode_ff <= cfg.mode;
      a_x_ff    <= req_sample;
      a_xe_ff   <= a_xe_in;
      a_eob_ff  <= req_end_of_block;
      a_addr_ff <= addr_ext[TABLE_INDEX_BITS-1:0];
      a_word_ff <= req_entry_word;
   end

   // bound checks and multiplier operand select
   always_comb begin
      diff = {a_xe_ff[SAMPLE_W-1], a_xe_ff} - {cfg.range_low[SAMPLE_W-1], cfg.range_low};
      negx = DIFF_W'(0) - {a_x_ff[SAMPLE_W-1], a_x_ff};
      use_leak = (a_mode_ff == MODE_LEAKY);
      b_ctl_in.eval  = a_eval_ff;
      b_ctl_in.mode  = a_mode_ff;
      b_ctl_in.eob   = a_eob_ff;
      b_ctl_in.x     = a_x_ff;
      b_ctl_in.below = $signed(a_xe_ff) < $signed(cfg.range_low);
      b_ctl_in.above = $signed(a_xe_ff) >= $signed(cfg.range_high);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff.eval <= 1'b0;
         b_wr_ff.en    <= 1'b0;
      end else begin
         b_ctl_ff   <= b_ctl_in;
         b_wr_ff.en <= a_write_ff;
      end
      b_wr_ff.addr <= a_addr_ff;
      b_wr_ff.word <= a_word_ff;
      b_opa_ff     <= use_leak ? negx : diff;
      b_opb_ff     <= use_leak ? {{(SCALE_W-SLOPE_W){1'b0}}, cfg.leak_slope}
                               : cfg.index_scale;
   end

   // one shared multiplier: table position or leaky magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff.eval <= 1'b0;
         c_wr_ff.en    <= 1'b0;
      end else begin
         c_ctl_ff <= b_ctl_ff;
         c_wr_ff  <= b_wr_ff;
      end
      c_prod_ff <= PROD_W'(b_opa_ff) * PROD_W'(b_opb_ff);
   end

   assign ctl    = c_ctl_ff;
   assign prod   = c_prod_ff;
   assign tbl_wr = c_wr_ff;

endmodule

/* design/acu_blend.sv */
module acu_blend import acu_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  item_ctl_type                ctl,
   input  logic [PROD_W-1:0]           prod,
   output logic [TABLE_INDEX_BITS-1:0] rd_addr_a,
   output logic [TABLE_INDEX_BITS-1:0] rd_addr_b,
   input  logic [WORD_W-1:0]           rd_data_a,
   input  logic [WORD_W-1:0]           rd_data_b,
   output logic                        rsp_valid,
   output logic signed [SAMPLE_W-1:0]  rsp_activation,
   output logic                        rsp_end_of_block_out
);

   logic [IND_W-1:0]           ind;
   logic                       ind_sat;
   logic [FRAC_W-1:0]          frac_in;
   logic [MAG_W-1:0]           mag;
   logic [DIFF_W-1:0]          neg_mag;
   logic signed [SAMPLE_W-1:0] leak_in;

   item_ctl_type               d_ctl_ff;
   logic [FRAC_W-1:0]          d_frac_ff;
   logic signed [SAMPLE_W-1:0] d_leak_ff;

   logic signed [WORD_W:0]     delta;
   logic signed [WORD_W+FRAC_W+1:0] step;
   logic signed [WORD_W+FRAC_W+2:0] acc;

   item_ctl_type               e_ctl_ff;
   logic signed [SAMPLE_W-1:0] e_leak_ff;
   logic [WORD_W-1:0]          e_interp_ff;

   logic [WORD_W:0]            sig;
   logic [SAMPLE_W-1:0]        tanh_val;
   logic signed [SAMPLE_W-1:0] act_in;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_act_ff;
   logic                       rsp_eob_ff;

   // table index with clamp at the last entry, fraction, leaky magnitude
   always_comb begin
      ind     = prod[PROD_W-1:POS_FRAC];
      ind_sat = ind >= IND_W'(TABLE_LAST);
      if (ind_sat) begin
         rd_addr_a = TABLE_INDEX_BITS'(TABLE_LAST);
         rd_addr_b = TABLE_INDEX_BITS'(TABLE_LAST);
         frac_in   = '0;
      end else begin
         rd_addr_a = ind[TABLE_INDEX_BITS-1:0];
         rd_addr_b = ind[TABLE_INDEX_BITS-1:0] + TABLE_INDEX_BITS'(1);
         frac_in   = prod[POS_FRAC-1:POS_FRAC-FRAC_W];
      end
      mag     = prod[PROD_W-1:FRAC_W];
      neg_mag = DIFF_W'(0) - mag[DIFF_W-1:0];
      leak_in = (mag > MAG_W'(LEAK_MAG_MAX)) ? SAMPLE_MIN : neg_mag[SAMPLE_W-1:0];
   end

   // hold item while the table words are read
   always_ff @(posedge clock) begin
      if (reset) begin
         d_ctl_ff.eval <= 1'b0;
      end else begin
         d_ctl_ff <= ctl;
      end
      d_frac_ff <= frac_in;
      d_leak_ff <= leak_in;
   end

   // blend adjacent entries: a + (b - a) * f, scaled by one
   always_comb begin
      delta = $signed({1'b0, rd_data_b}) - $signed({1'b0, rd_data_a});
      step  = delta * $signed({1'b0, d_frac_ff});
      acc   = $signed({2'b00, rd_data_a, {FRAC_W{1'b0}}}) + {step[WORD_W+FRAC_W+1], step};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ctl_ff.eval <= 1'b0;
      end else begin
         e_ctl_ff <= d_ctl_ff;
      end
      e_leak_ff   <= d_leak_ff;
      e_interp_ff <= acc[WORD_W+FRAC_W-1:FRAC_W];
   end

   // pick the function for the item's mode
   always_comb begin
      if (e_ctl_ff.below) begin
         sig = '0;
      end else if (e_ctl_ff.above) begin
         sig = (WORD_W+1)'(Q_ONE);
      end else begin
         sig = {1'b0, e_interp_ff};
      end
      tanh_val = {2'b00, sig, 1'b0} - SAMPLE_W'(Q_ONE);
      unique case (e_ctl_ff.mode)
         MODE_RELU: begin
            act_in = e_ctl_ff.x[SAMPLE_W-1] ? '0 : e_ctl_ff.x;
         end
         MODE_LEAKY: begin
            act_in = e_ctl_ff.x[SAMPLE_W-1] ? e_leak_ff : e_ctl_ff.x;
         end
         MODE_SIGMOID: begin
            act_in = {{(SAMPLE_W-WORD_W-1){1'b0}}, sig};
         end
         MODE_TANH: begin
            act_in = tanh_val;
         end
         default: begin
            act_in = e_ctl_ff.x;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= e_ctl_ff.eval;
      end
      rsp_act_ff <= act_in;
      rsp_eob_ff <= e_ctl_ff.eob;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_activation       = rsp_act_ff;
   assign rsp_end_of_block_out = rsp_eob_ff;

endmodule

/* design/activation_unit_top.sv */
// Elementwise activation on signed Q4.11 words: relu, leaky relu, table
// sigmoid with linear interpolation, tanh from the sigmoid, or pass-through,
// as the mode register selects. The unit takes one word per clock and busy
// never rises, since every stage advances each cycle and the receiver cannot
// stall. Six register stages (capture, bound compare, shared multiply, table
// read, blend, output select) lie between a word and its result: each
// evaluate word raises its result strobe rsp_valid for one cycle from the
// output select register, and results leave in order. A table-write
// word (req_opcode high) updates the 256-word sigmoid table at the same
// pipeline point where evaluates read it, so every word sees the table as
// left by the words before it; writes give no result.
// The table is one memory with two read ports (the two neighbor entries),
// and one shared multiplier forms the table position or the leaky product.
// Table entries read before they are written give undefined values. Change
// registers only while no words are in flight.
module activation_unit_top import acu_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic signed [SAMPLE_W-1:0]   req_sample,
   input  logic [ENTRY_W-1:0]           req_entry_index,
   input  logic [WORD_W-1:0]            req_entry_word,
   input  logic                         req_end_of_block,
   output logic                         rsp_valid,
   output logic signed [SAMPLE_W-1:0]   rsp_activation,
   output logic                         rsp_end_of_block_out,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_W-1:0]        paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   cfg_type                     cfg_ff;
   logic                        csr_wr;
   logic [2:0]                  csr_idx;
   logic                        accept;
   item_ctl_type                ctl;
   logic [PROD_W-1:0]           prod;
   tbl_wr_type                  tbl_wr;
   logic [TABLE_INDEX_BITS-1:0] rd_addr_a;
   logic [TABLE_INDEX_BITS-1:0] rd_addr_b;
   logic [WORD_W-1:0]           rd_data_a;
   logic [WORD_W-1:0]           rd_data_b;

   assign busy    = 1'b0;
   assign pready  = 1'b1;
   assign accept  = start && !busy;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[4:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= MODE_RELU;
         cfg_ff.leak_slope  <= LEAK_SLOPE_RST;
         cfg_ff.range_low   <= RANGE_LOW_RST;
         cfg_ff.range_high  <= RANGE_HIGH_RST;
         cfg_ff.index_scale <= INDEX_SCALE_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_MODE:        cfg_ff.mode        <= pwdata[MODE_W-1:0];
            CSR_LEAK_SLOPE:  cfg_ff.leak_slope  <= pwdata[SLOPE_W-1:0];
            CSR_RANGE_LOW:   cfg_ff.range_low   <= pwdata[SAMPLE_W-1:0];
            CSR_RANGE_HIGH:  cfg_ff.range_high  <= pwdata[SAMPLE_W-1:0];
            CSR_INDEX_SCALE: cfg_ff.index_scale <= pwdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_idx)
         CSR_MODE:        prdata = {{(32-MODE_W){1'b0}}, cfg_ff.mode};
         CSR_LEAK_SLOPE:  prdata = {{(32-SLOPE_W){1'b0}}, cfg_ff.leak_slope};
         CSR_RANGE_LOW:   prdata = 32'(cfg_ff.range_low);
         CSR_RANGE_HIGH:  prdata = 32'(cfg_ff.range_high);
         CSR_INDEX_SCALE: prdata = {{(32-SCALE_W){1'b0}}, cfg_ff.index_scale};
         default:         prdata = '0;
      endcase
   end

   acu_index u_index (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_opcode       (req_opcode),
      .req_sample       (req_sample),
      .req_entry_index  (req_entry_index),
      .req_entry_word   (req_entry_word),
      .req_end_of_block (req_end_of_block),
      .cfg              (cfg_ff),
      .ctl              (ctl),
      .prod             (prod),
      .tbl_wr           (tbl_wr)
   );

   acu_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock     (clock),
      .wr_en     (tbl_wr.en),
      .wr_addr   (tbl_wr.addr),
      .wr_data   (tbl_wr.word),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   acu_blend u_blend (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (ctl),
      .prod                 (prod),
      .rd_addr_a            (rd_addr_a),
      .rd_addr_b            (rd_addr_b),
      .rd_data_a            (rd_data_a),
      .rd_data_b            (rd_data_b),
      .rsp_valid            (rsp_valid),
      .rsp_activation       (rsp_activation),
      .rsp_end_of_block_out (rsp_end_of_block_out)
   );

`ifndef ASSERT_OFF
   a_eval_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_opcode) |-> ##PIPE_LAT rsp_valid)
      else $error("evaluate word lost its result");

   a_write_is_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode) |-> ##PIPE_LAT !rsp_valid)
      else $error("table write produced a result");

   a_eob_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_end_of_block_out == $past(req_end_of_block, PIPE_LAT)))
      else $error("end-of-block mark out of step");
`endif

endmodule
